[hdl/hmp_pkg.sv]
// ----------------------------------------------------------------------------
// hmp_pkg
// Types and constants shared by the height motion profile unit.
// ----------------------------------------------------------------------------
package hmp_pkg;

  localparam int DIGIT_W  = 8;
  localparam int MUL_A_W  = 31;
  localparam int MUL_B_W  = 48;
  localparam int MUL_S_W  = MUL_A_W + DIGIT_W;
  localparam int NDIG_W   = 3;
  localparam int CFG_IDX_W = 3;

  localparam logic [NDIG_W-1:0] SQ_DIGITS   = 3'd4;
  localparam logic [NDIG_W-1:0] STOP_DIGITS = 3'd6;
  localparam logic [NDIG_W-1:0] DT_DIGITS   = 3'd3;

  localparam logic [23:0] DT_SHORT_MAX = 24'd16;
  localparam logic [23:0] DT_ONE_MS    = 24'd16777;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_HEIGHT = 3'd0,
    CFG_MAX_HEIGHT = 3'd1,
    CFG_MAX_SPEED  = 3'd2,
    CFG_MAX_ACCEL  = 3'd3,
    CFG_STOP_GAIN  = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_STOP,
    ST_ACC,
    ST_MOVE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic signed [31:0] min_height;
    logic signed [31:0] max_height;
    logic [30:0]        max_speed;
    logic [30:0]        max_accel;
    logic [30:0]        stop_gain;
  } cfg_regs_t;

  localparam cfg_regs_t CFG_RESET = '{
    min_height: 32'sd0,
    max_height: 32'sd12976128,
    max_speed:  31'd655360,
    max_accel:  31'd1310720,
    stop_gain:  31'd1638
  };

  typedef struct packed {
    logic               action;
    logic signed [31:0] target_height;
    logic [23:0]        step_time;
    logic signed [31:0] start_height;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] height_ref;
    logic signed [31:0] height_rate_ref;
    logic signed [31:0] clamped_target;
  } out_item_t;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
    logic [NDIG_W-1:0]  ndig;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic [MUL_A_W-1:0] hi;
    logic [MUL_B_W-1:0] lo;
  } mul_rsp_t;

endpackage

[hdl/hmp_mul.sv]
// ----------------------------------------------------------------------------
// hmp_mul
// Digit-serial unsigned multiplier. The multiplier operand is shifted out
// one digit per cycle; product low digits shift into the same register.
// ----------------------------------------------------------------------------
module hmp_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  hmp_pkg::mul_req_t req,
  output hmp_pkg::mul_rsp_t rsp
);
  import hmp_pkg::*;

  logic [MUL_A_W-1:0] a_r, a_nxt;
  logic [MUL_A_W-1:0] hi_r, hi_nxt;
  logic [MUL_B_W-1:0] lo_r, lo_nxt;
  logic [NDIG_W-1:0]  cnt_r, cnt_nxt;
  logic               done_r, done_nxt;
  logic [MUL_S_W-1:0] sum;

  assign sum = MUL_S_W'(hi_r) + MUL_S_W'(a_r) * MUL_S_W'(lo_r[DIGIT_W-1:0]);

  always_comb begin
    a_nxt    = a_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (req.start) begin
      a_nxt   = req.a;
      hi_nxt  = '0;
      lo_nxt  = req.b;
      cnt_nxt = req.ndig;
    end else if (cnt_r != '0) begin
      hi_nxt   = sum[MUL_S_W-1:DIGIT_W];
      lo_nxt   = {sum[DIGIT_W-1:0], lo_r[MUL_B_W-1:DIGIT_W]};
      cnt_nxt  = cnt_r - NDIG_W'(1);
      done_nxt = (cnt_r == NDIG_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r  <= a_nxt;
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
  end

  assign rsp = '{done: done_r, hi: hi_r, lo: lo_r};

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> cnt_r == '0)
    else $error("multiplier restarted while busy");

  a_start_load: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> cnt_r == $past(req.ndig))
    else $error("digit count not loaded");

  a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> cnt_r == '0)
    else $error("done raised with digits left");

endmodule

[hdl/hmp_core.sv]
// ----------------------------------------------------------------------------
// hmp_core
// Step sequencer: clamps, runs a step item's four products on the shared
// multiplier, slews speed and height, loads reset items, holds the result.
// ----------------------------------------------------------------------------
module hmp_core (
  input  logic               clk,
  input  logic               rst_n,
  input  hmp_pkg::cfg_regs_t cfg,
  input  logic               in_valid,
  output logic               in_stall,
  input  hmp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output hmp_pkg::out_item_t out_data,
  output hmp_pkg::mul_req_t  mul_req,
  input  hmp_pkg::mul_rsp_t  mul_rsp
);
  import hmp_pkg::*;

  function automatic logic signed [31:0] clamp_band(input logic signed [31:0] v,
                                                    input logic signed [31:0] lo,
                                                    input logic signed [31:0] hi);
    if (v > hi) clamp_band = hi;
    else if (v < lo) clamp_band = lo;
    else clamp_band = v;
  endfunction

  function automatic logic signed [31:0] slew(input logic signed [31:0] cur,
                                              input logic signed [31:0] goal,
                                              input logic [30:0]        stp);
    logic signed [32:0] d;
    logic signed [32:0] s;
    logic signed [32:0] up;
    logic signed [32:0] dn;
    d  = 33'(goal) - 33'(cur);
    s  = $signed({2'b00, stp});
    up = 33'(cur) + s;
    dn = 33'(cur) - s;
    if (d > s) slew = up[31:0];
    else if (d < -s) slew = dn[31:0];
    else slew = goal;
  endfunction

  function automatic logic [30:0] mag31(input logic signed [31:0] v);
    logic signed [31:0] t;
    t = v[31] ? -v : v;
    mag31 = t[30:0];
  endfunction

  state_t             state_r, state_nxt;
  logic signed [31:0] height_r, height_nxt;
  logic signed [31:0] rate_r, rate_nxt;
  logic signed [31:0] target_r, target_nxt;
  logic [23:0]        dt_r, dt_nxt;
  logic [31:0]        dist_mag_r, dist_mag_nxt;
  logic               dist_neg_r, dist_neg_nxt;
  logic signed [31:0] desired_r, desired_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  logic signed [31:0] start_clamped;
  logic signed [31:0] step_target;
  logic signed [32:0] diff;
  logic signed [32:0] diff_abs;
  logic [45:0]        vv;
  logic               near;
  logic signed [31:0] speed_pos;
  logic signed [31:0] rate_slewed;

  assign start_clamped = clamp_band(in_data.start_height, cfg.min_height, cfg.max_height);
  assign step_target   = clamp_band(in_data.target_height, cfg.min_height, cfg.max_height);
  assign diff          = 33'(step_target) - 33'(height_r);
  assign diff_abs      = diff[32] ? -diff : diff;
  assign vv            = {mul_rsp.hi[29:0], mul_rsp.lo[47:32]};
  assign near          = (mul_rsp.hi != '0) || (mul_rsp.lo >= {dist_mag_r, 16'h0000});
  assign speed_pos     = $signed({1'b0, cfg.max_speed});
  assign rate_slewed   = slew(rate_r, desired_r, mul_rsp.hi);

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    height_nxt    = height_r;
    rate_nxt      = rate_r;
    target_nxt    = target_r;
    dt_nxt        = dt_r;
    dist_mag_nxt  = dist_mag_r;
    dist_neg_nxt  = dist_neg_r;
    desired_nxt   = desired_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mul_req       = '0;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.action) begin
            height_nxt = start_clamped;
            rate_nxt   = '0;
            target_nxt = start_clamped;
            state_nxt  = ST_DONE;
          end else begin
            target_nxt   = step_target;
            dt_nxt       = (in_data.step_time <= DT_SHORT_MAX) ? DT_ONE_MS
                                                               : in_data.step_time;
            dist_neg_nxt = diff[32];
            dist_mag_nxt = diff_abs[31:0];
            mul_req      = '{start: 1'b1, a: mag31(rate_r),
                             b: MUL_B_W'(mag31(rate_r)), ndig: SQ_DIGITS};
            state_nxt    = ST_SQ;
          end
        end
      end
      ST_SQ: begin
        if (mul_rsp.done) begin
          mul_req   = '{start: 1'b1, a: cfg.stop_gain, b: MUL_B_W'(vv), ndig: STOP_DIGITS};
          state_nxt = ST_STOP;
        end
      end
      ST_STOP: begin
        if (mul_rsp.done) begin
          if (near) desired_nxt = '0;
          else desired_nxt = dist_neg_r ? -speed_pos : speed_pos;
          mul_req   = '{start: 1'b1, a: cfg.max_accel, b: MUL_B_W'(dt_r), ndig: DT_DIGITS};
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        if (mul_rsp.done) begin
          rate_nxt  = rate_slewed;
          mul_req   = '{start: 1'b1, a: mag31(rate_slewed), b: MUL_B_W'(dt_r),
                        ndig: DT_DIGITS};
          state_nxt = ST_MOVE;
        end
      end
      ST_MOVE: begin
        if (mul_rsp.done) begin
          height_nxt = slew(height_r, target_r, mul_rsp.hi);
          state_nxt  = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{height_ref: height_r, height_rate_ref: rate_r,
                            clamped_target: target_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      height_r    <= '0;
      rate_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      height_r    <= height_nxt;
      rate_r      <= rate_nxt;
    end
  end

  always_ff @(posedge clk) begin
    target_r   <= target_nxt;
    dt_r       <= dt_nxt;
    dist_mag_r <= dist_mag_nxt;
    dist_neg_r <= dist_neg_nxt;
    desired_r  <= desired_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mul_rsp.done |-> (state_r == ST_SQ || state_r == ST_STOP ||
                      state_r == ST_ACC || state_r == ST_MOVE))
    else $error("product finished with no step in flight");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result loaded outside the finish state");

  a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_valid_r && out_stall) |=> state_r == ST_DONE)
    else $error("result register overwritten while stalled");

endmodule

[hdl/height_motion_profile_unit.sv]
// ----------------------------------------------------------------------------
// height_motion_profile_unit
// Step item: four dependent products on one 8-bit-digit multiplier
// (4 + 6 + 3 + 3 digits), each loaded and then run in turn, lie between
// input transfer and result register; in_stall holds off the next item.
// Reset item: loads the clamped start height, then the result register.
// Reset clears height and speed state and loads the register defaults.
// ----------------------------------------------------------------------------
module height_motion_profile_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [hmp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                      cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  hmp_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output hmp_pkg::out_item_t               out_data
);
  import hmp_pkg::*;

  cfg_regs_t cfg_r, cfg_nxt;
  mul_req_t  mul_req;
  mul_rsp_t  mul_rsp;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MIN_HEIGHT: cfg_nxt.min_height = $signed(cfg_wdata);
        CFG_MAX_HEIGHT: cfg_nxt.max_height = $signed(cfg_wdata);
        CFG_MAX_SPEED:  cfg_nxt.max_speed  = cfg_wdata[30:0];
        CFG_MAX_ACCEL:  cfg_nxt.max_accel  = cfg_wdata[30:0];
        CFG_STOP_GAIN:  cfg_nxt.stop_gain  = cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  hmp_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  hmp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .mul_req   (mul_req),
    .mul_rsp   (mul_rsp)
  );

endmodule
